// ===== rtl/gofs_pkg.sv =====
package gofs_pkg;

  localparam int MAX_SIDE    = 32;
  localparam int SIDE_W      = $clog2(MAX_SIDE);
  localparam int NCELLS      = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W      = $clog2(NCELLS);
  localparam int ACTOR_SLOTS = 4;
  localparam int ID_W        = 8;
  localparam int CNT_W       = 3;
  localparam int COUNT_MAX   = 7;
  localparam int ROW_W       = CNT_W + ACTOR_SLOTS * ID_W;
  localparam int QUEUE_DEPTH = 1024;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int COORD_W     = 16;
  localparam int HALF_W      = 15;
  localparam int NCPS_W      = 6;
  localparam int OUT_IDX_W   = 5;
  localparam int ACT_W       = 2;
  localparam int REG_IDX_W   = 3;
  localparam int PROD_W      = HALF_W + 1 + SIDE_W;
  localparam int POS_W       = 24;
  localparam int DIST_W      = 2 * POS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_MARK      = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_NEAREST   = 2'd2,
    ACT_FIND_FREE = 2'd3
  } action_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORIGIN_X       = 3'd0,
    REG_ORIGIN_Y       = 3'd1,
    REG_ORIGIN_Z       = 3'd2,
    REG_CELL_SIZE      = 3'd3,
    REG_GRID_SIDE      = 3'd4,
    REG_CELLS_PER_SIDE = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_MARK_END,
    ST_NEAR,
    ST_NEAR_END,
    ST_START_RD,
    ST_START_CHK,
    ST_DEQ,
    ST_DEQ_DATA,
    ST_NB,
    ST_NB_CHK,
    ST_NB_DIST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] origin_z;
    logic [HALF_W-1:0]  cell_size;
    logic [HALF_W-1:0]  grid_side;
    logic [NCPS_W-1:0]  cells_per_side;
  } cfg_t;

  // Q12.4 coordinate doubled into the internal Q19.5 position width
  function automatic logic signed [POS_W-1:0] dbl(logic [COORD_W-1:0] v);
    return {{(POS_W-COORD_W-1){v[COORD_W-1]}}, v, 1'b0};
  endfunction

  function automatic logic signed [POS_W-1:0] uext(logic [HALF_W-1:0] v);
    return {{(POS_W-HALF_W){1'b0}}, v};
  endfunction

  function automatic logic signed [POS_W-1:0] cell_step(cfg_t c, logic [SIDE_W-1:0] i);
    logic [PROD_W-1:0] p;
    p = PROD_W'(c.cell_size) * PROD_W'(i);
    p = {p[PROD_W-2:0], 1'b0};
    return {{(POS_W-PROD_W){1'b0}}, p};
  endfunction

  // doubled centre of column cx
  function automatic logic signed [POS_W-1:0] cen_x(cfg_t c, logic [SIDE_W-1:0] cx);
    return dbl(c.origin_x) - uext(c.grid_side) + uext(c.cell_size) + cell_step(c, cx);
  endfunction

  // doubled centre of row cz
  function automatic logic signed [POS_W-1:0] cen_z(cfg_t c, logic [SIDE_W-1:0] cz);
    return cell_step(c, cz) - dbl(c.origin_z) - uext(c.grid_side) + uext(c.cell_size);
  endfunction

endpackage

// ===== rtl/gofs_ifs.sv =====
interface gofs_item_if import gofs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic [ID_W-1:0]           actor_id;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic [HALF_W-1:0]         half_width;
  logic [HALF_W-1:0]         half_depth;
  logic signed [COORD_W-1:0] owner_x;
  logic signed [COORD_W-1:0] owner_y;
  logic signed [COORD_W-1:0] owner_z;
  logic                      diagonal;

  modport source (output valid, action, actor_id, point_x, point_y, point_z, half_width,
                  half_depth, owner_x, owner_y, owner_z, diagonal, input ready);
  modport sink (input valid, action, actor_id, point_x, point_y, point_z, half_width,
                half_depth, owner_x, owner_y, owner_z, diagonal, output ready);
endinterface

interface gofs_res_if import gofs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [OUT_IDX_W-1:0] cell_x;
  logic [OUT_IDX_W-1:0] cell_z;
  logic                 overflow;

  modport source (output valid, found, cell_x, cell_z, overflow, input ready);
  modport sink (input valid, found, cell_x, cell_z, overflow, output ready);
endinterface

interface gofs_cfg_if import gofs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gofs_ram.sv =====
module gofs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gofs_dist.sv =====
// Squared distance from a cell centre to a query point, three register stages.
module gofs_dist import gofs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  logic [CELL_W-1:0]  in_idx,
  input  logic [COORD_W-1:0] qx,
  input  logic [COORD_W-1:0] qy,
  input  logic [COORD_W-1:0] qz,
  output logic               out_valid,
  output logic [CELL_W-1:0]  out_idx,
  output logic [DIST_W-1:0]  sq_dist
);

  logic                     va, vb;
  logic [CELL_W-1:0]        ia, ib;
  logic signed [POS_W-1:0]  dxa, dya, dza;
  logic signed [DIST_W-1:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    ia      <= in_idx;
    dxa     <= cen_x(cfg, in_idx[SIDE_W-1:0]) - dbl(qx);
    dya     <= dbl(cfg.origin_y) - dbl(qy);
    dza     <= cen_z(cfg, in_idx[CELL_W-1:SIDE_W]) - dbl(qz);
    ib      <= ia;
    sx      <= dxa * dxa;
    sy      <= dya * dya;
    sz      <= dza * dza;
    out_idx <= ib;
    sq_dist <= unsigned'(sx + sy + sz);
  end

endmodule

// ===== rtl/grid_occupancy_free_cell_search.sv =====
// Occupancy grid of up to 32 x 32 cells with a free-cell search. After reset the block
// clears all 1024 cell addresses of the cell store before it takes its first item;
// configuration writes are taken at any time. Mark and nearest sweep all 1024 cell
// addresses, one a cycle, and reset all clears the store the same way. Find free adds to
// the nearest sweep a flood through the cell store: each dequeued cell is read from the
// queue, then each neighbour slot is skipped (the centre, off-grid or disallowed diagonal)
// or probed, and each free neighbour has its squared distance taken by the three-stage
// distance unit. The single-port-per-side cell memory sets the pace of the flood.
module grid_occupancy_free_cell_search import gofs_pkg::*; (
  input logic        clk,
  input logic        rst,
  gofs_cfg_if.sink   cfg,
  gofs_item_if.sink  item,
  gofs_res_if.source result
);

  localparam logic [3:0] K_CENTER = 4'd4;
  localparam logic [3:0] K_END    = 4'd9;

  cfg_t cfg_q;

  state_t state, state_next;

  action_t              act_q;
  logic [ID_W-1:0]      who_q;
  logic [COORD_W-1:0]   px_q, py_q, pz_q, ox_q, oy_q, oz_q;
  logic [HALF_W-1:0]    hw_q, hd_q;
  logic                 diag_q;

  logic [CELL_W-1:0]    sweep;
  logic [1:0]           drain;
  logic                 init_done;
  logic [CELL_W-1:0]    best;
  logic [DIST_W-1:0]    bestd;
  logic                 near_have;
  logic                 pend_found;
  logic [CELL_W-1:0]    pend_idx;
  logic                 ovf;
  logic [QPTR_W-1:0]    head;
  logic [QPTR_W:0]      cnt;
  logic [CELL_W-1:0]    cur;
  logic [3:0]           k;
  logic [CELL_W-1:0]    nb_q;
  logic [ID_W-1:0]      blocker;
  logic                 enq_q;
  logic                 mk_valid;
  logic [CELL_W-1:0]    mk_idx;

  logic                 res_valid, res_found, res_ovf;
  logic [OUT_IDX_W-1:0] res_x, res_z;

  // memory ports
  logic                 cm_we, cm_re;
  logic [CELL_W-1:0]    cm_waddr, cm_raddr;
  logic [ROW_W-1:0]     cm_wdata, cm_rdata;
  logic                 vm_we, vm_re, vm_wdata, vm_rdata;
  logic [CELL_W-1:0]    vm_waddr, vm_raddr;
  logic                 qm_we, qm_re;
  logic [QPTR_W-1:0]    qm_waddr, qm_raddr;
  logic [CELL_W-1:0]    qm_wdata, qm_rdata;

  logic                 d_in_valid, d_out_valid;
  logic [CELL_W-1:0]    d_in_idx, d_out_idx;
  logic [COORD_W-1:0]   d_qx, d_qy, d_qz;
  logic [DIST_W-1:0]    d_dist;

  logic                 accept;
  logic [NCPS_W-1:0]    n_side;
  logic                 sweep_in_grid, mark_hit;
  logic                 row_free, row_holds, enq_ok, better, enq;
  logic signed [1:0]    dxo, dzo;
  logic signed [SIDE_W+1:0] nx, nz;
  logic                 nb_ok;
  logic [CELL_W-1:0]    nb;
  logic [CNT_W-1:0]     mk_c;
  logic                 mk_store;
  logic [ROW_W-1:0]     mk_row;
  logic signed [POS_W-1:0] mx, mz, ms, ml, mr, md, mt;

  function automatic logic is_free(logic [ROW_W-1:0] row, logic [ID_W-1:0] owner);
    logic [CNT_W-1:0] c;
    c = row[ROW_W-1 -: CNT_W];
    return (c == '0) || ((c == CNT_W'(1)) && (row[ID_W-1:0] == owner));
  endfunction

  function automatic logic holds(logic [ROW_W-1:0] row, logic [ID_W-1:0] id);
    logic [CNT_W-1:0] c;
    logic             hit;
    c   = row[ROW_W-1 -: CNT_W];
    hit = 1'b0;
    for (int s = 0; s < ACTOR_SLOTS; s++) begin
      if ((int'(c) > s) && (row[s*ID_W +: ID_W] == id)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // neighbour offsets: x outer, z inner, both from -1 to 1
  function automatic logic [3:0] nb_off(logic [3:0] kk);
    logic [3:0] o;
    unique case (kk)
      4'd0:    o = {2'b11, 2'b11};
      4'd1:    o = {2'b11, 2'b00};
      4'd2:    o = {2'b11, 2'b01};
      4'd3:    o = {2'b00, 2'b11};
      4'd5:    o = {2'b00, 2'b01};
      4'd6:    o = {2'b01, 2'b11};
      4'd7:    o = {2'b01, 2'b00};
      4'd8:    o = {2'b01, 2'b01};
      default: o = 4'b0000;
    endcase
    return o;
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.origin_x       <= '0;
      cfg_q.origin_y       <= '0;
      cfg_q.origin_z       <= '0;
      cfg_q.cell_size      <= HALF_W'(16);
      cfg_q.grid_side      <= HALF_W'(512);
      cfg_q.cells_per_side <= NCPS_W'(32);
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_ORIGIN_X:       cfg_q.origin_x       <= cfg.data;
        REG_ORIGIN_Y:       cfg_q.origin_y       <= cfg.data;
        REG_ORIGIN_Z:       cfg_q.origin_z       <= cfg.data;
        REG_CELL_SIZE:      cfg_q.cell_size      <= cfg.data[HALF_W-1:0];
        REG_GRID_SIDE:      cfg_q.grid_side      <= cfg.data[HALF_W-1:0];
        REG_CELLS_PER_SIDE: cfg_q.cells_per_side <= cfg.data[NCPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_q.cells_per_side == '0) begin
      n_side = NCPS_W'(1);
    end else if (cfg_q.cells_per_side > NCPS_W'(MAX_SIDE)) begin
      n_side = NCPS_W'(MAX_SIDE);
    end else begin
      n_side = cfg_q.cells_per_side;
    end
  end

  assign accept = item.valid && item.ready;

  // mark box overlap for the swept cell, closed intervals
  always_comb begin
    mx = cen_x(cfg_q, sweep[SIDE_W-1:0]);
    mz = cen_z(cfg_q, sweep[CELL_W-1:SIDE_W]);
    ms = uext(cfg_q.cell_size);
    ml = dbl(px_q) - (uext(hw_q) <<< 1);
    mr = dbl(px_q) + (uext(hw_q) <<< 1);
    md = dbl(pz_q) - (uext(hd_q) <<< 1);
    mt = dbl(pz_q) + (uext(hd_q) <<< 1);
    sweep_in_grid = (NCPS_W'(sweep[SIDE_W-1:0]) < n_side) &&
                    (NCPS_W'(sweep[CELL_W-1:SIDE_W]) < n_side);
    mark_hit = sweep_in_grid && (mx + ms >= ml) && (mx - ms <= mr) &&
               (mz + ms >= md) && (mz - ms <= mt);
  end

  // append the actor to the row read for the pending mark
  always_comb begin
    mk_c     = cm_rdata[ROW_W-1 -: CNT_W];
    mk_store = (int'(mk_c) < ACTOR_SLOTS) && (int'(mk_c) < COUNT_MAX);
    mk_row   = cm_rdata;
    for (int s = 0; s < ACTOR_SLOTS; s++) begin
      if (mk_store && (int'(mk_c) == s)) begin
        mk_row[s*ID_W +: ID_W] = who_q;
      end
    end
    if (int'(mk_c) < COUNT_MAX) begin
      mk_row[ROW_W-1 -: CNT_W] = mk_c + CNT_W'(1);
    end
  end

  // neighbour of the current flood cell
  always_comb begin
    {dxo, dzo} = nb_off(k);
    nx = $signed({2'b00, cur[SIDE_W-1:0]}) + $signed({{SIDE_W{dxo[1]}}, dxo});
    nz = $signed({2'b00, cur[CELL_W-1:SIDE_W]}) + $signed({{SIDE_W{dzo[1]}}, dzo});
    nb = {nz[SIDE_W-1:0], nx[SIDE_W-1:0]};
    nb_ok = (k != K_CENTER) && (diag_q || (dxo == 2'sd0) || (dzo == 2'sd0)) &&
            !nx[SIDE_W+1] && !nz[SIDE_W+1] &&
            (NCPS_W'(nx[SIDE_W:0]) < n_side) && (NCPS_W'(nz[SIDE_W:0]) < n_side);
  end

  assign row_free  = is_free(cm_rdata, who_q);
  assign row_holds = holds(cm_rdata, blocker);
  assign enq_ok    = !vm_rdata && row_holds && (cnt < (QPTR_W+1)'(QUEUE_DEPTH));
  assign better    = !pend_found || (d_dist < bestd);
  assign enq       = ((state == ST_NB_CHK) && !row_free && enq_ok) ||
                     ((state == ST_NB_DIST) && d_out_valid && !better && enq_q);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:     if (&sweep) state_next = init_done ? ST_DONE : ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (action_t'(item.action))
            ACT_MARK:  state_next = ST_MARK;
            ACT_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_NEAR;
          endcase
        end
      end
      ST_MARK:      if (&sweep) state_next = ST_MARK_END;
      ST_MARK_END:  state_next = ST_DONE;
      ST_NEAR:      if (&sweep) state_next = ST_NEAR_END;
      ST_NEAR_END: begin
        if (drain == 2'd2) begin
          state_next = (act_q == ACT_FIND_FREE) ? ST_START_RD : ST_DONE;
        end
      end
      ST_START_RD:  state_next = ST_START_CHK;
      ST_START_CHK: state_next = row_free ? ST_DONE : ST_DEQ;
      ST_DEQ:       state_next = (cnt == '0) ? ST_DONE : ST_DEQ_DATA;
      ST_DEQ_DATA:  state_next = ST_NB;
      ST_NB: begin
        if (k == K_END) begin
          state_next = ST_DEQ;
        end else if (nb_ok) begin
          state_next = ST_NB_CHK;
        end
      end
      ST_NB_CHK:    state_next = row_free ? ST_NB_DIST : ST_NB;
      ST_NB_DIST:   if (d_out_valid) state_next = ST_NB;
      ST_DONE:      if (!res_valid || result.ready) state_next = ST_IDLE;
      default:      state_next = ST_CLEAR;
    endcase
  end

  // memory and unit controls
  always_comb begin
    item.ready = (state == ST_IDLE);
    cm_we      = 1'b0;
    cm_waddr   = mk_idx;
    cm_wdata   = mk_row;
    cm_re      = 1'b0;
    cm_raddr   = sweep;
    vm_we      = 1'b0;
    vm_waddr   = nb_q;
    vm_wdata   = 1'b1;
    vm_re      = 1'b0;
    vm_raddr   = nb;
    qm_we      = 1'b0;
    qm_waddr   = head + cnt[QPTR_W-1:0];
    qm_wdata   = nb_q;
    qm_re      = 1'b0;
    qm_raddr   = head;
    d_in_valid = 1'b0;
    d_in_idx   = nb_q;
    d_qx       = ox_q;
    d_qy       = oy_q;
    d_qz       = oz_q;
    if (mk_valid) begin
      cm_we = 1'b1;
    end
    if (enq) begin
      qm_we = 1'b1;
      vm_we = 1'b1;
    end
    unique case (state)
      ST_CLEAR: begin
        cm_we    = 1'b1;
        cm_waddr = sweep;
        cm_wdata = '0;
      end
      ST_MARK: begin
        cm_re = mark_hit;
      end
      ST_NEAR: begin
        vm_we      = 1'b1;
        vm_waddr   = sweep;
        vm_wdata   = 1'b0;
        d_in_valid = sweep_in_grid;
        d_in_idx   = sweep;
        d_qx       = px_q;
        d_qy       = py_q;
        d_qz       = pz_q;
      end
      ST_START_RD: begin
        cm_re    = 1'b1;
        cm_raddr = best;
      end
      ST_START_CHK: begin
        if (!row_free) begin
          vm_we    = 1'b1;
          vm_waddr = best;
          qm_we    = 1'b1;
          qm_waddr = '0;
          qm_wdata = best;
        end
      end
      ST_DEQ: begin
        qm_re = (cnt != '0);
      end
      ST_NB: begin
        if (k != K_END && nb_ok) begin
          cm_re    = 1'b1;
          cm_raddr = nb;
          vm_re    = 1'b1;
        end
      end
      ST_NB_CHK: begin
        d_in_valid = row_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      mk_valid  <= 1'b0;
      sweep     <= '0;
      init_done <= 1'b0;
    end else begin
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          sweep <= sweep + CELL_W'(1);
          if (&sweep) init_done <= 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            act_q      <= action_t'(item.action);
            who_q      <= item.actor_id;
            px_q       <= item.point_x;
            py_q       <= item.point_y;
            pz_q       <= item.point_z;
            hw_q       <= item.half_width;
            hd_q       <= item.half_depth;
            ox_q       <= item.owner_x;
            oy_q       <= item.owner_y;
            oz_q       <= item.owner_z;
            diag_q     <= item.diagonal;
            sweep      <= '0;
            pend_found <= 1'b0;
            pend_idx   <= '0;
            ovf        <= 1'b0;
            near_have  <= 1'b0;
          end
        end
        ST_MARK: begin
          sweep    <= sweep + CELL_W'(1);
          mk_valid <= mark_hit;
          mk_idx   <= sweep;
        end
        ST_MARK_END: mk_valid <= 1'b0;
        ST_NEAR: begin
          sweep <= sweep + CELL_W'(1);
          drain <= '0;
        end
        ST_NEAR_END: drain <= drain + 2'd1;
        ST_START_CHK: begin
          if (row_free) begin
            pend_found <= 1'b1;
            pend_idx   <= best;
          end else begin
            blocker <= cm_rdata[ID_W-1:0];
            head    <= '0;
            cnt     <= (QPTR_W+1)'(1);
          end
        end
        ST_DEQ: begin
          if (cnt != '0) begin
            head <= head + QPTR_W'(1);
            cnt  <= cnt - (QPTR_W+1)'(1);
          end
        end
        ST_DEQ_DATA: begin
          cur <= qm_rdata;
          k   <= '0;
        end
        ST_NB: begin
          nb_q <= nb;
          if (k != K_END && !nb_ok) k <= k + 4'd1;
        end
        ST_NB_CHK: begin
          enq_q <= enq_ok;
          if (!row_free) k <= k + 4'd1;
        end
        ST_NB_DIST: begin
          if (d_out_valid) begin
            k <= k + 4'd1;
            if (better) begin
              pend_found <= 1'b1;
              pend_idx   <= nb_q;
              bestd      <= d_dist;
            end
          end
        end
        ST_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_ovf   <= ovf;
            if (act_q == ACT_NEAREST) begin
              res_found <= 1'b1;
              res_x     <= OUT_IDX_W'(best[SIDE_W-1:0]);
              res_z     <= OUT_IDX_W'(best[CELL_W-1:SIDE_W]);
            end else begin
              res_found <= pend_found;
              res_x     <= OUT_IDX_W'(pend_idx[SIDE_W-1:0]);
              res_z     <= OUT_IDX_W'(pend_idx[CELL_W-1:SIDE_W]);
            end
          end
        end
        default: ;
      endcase
      if (enq) begin
        cnt <= cnt + (QPTR_W+1)'(1);
      end
      if (mk_valid && !mk_store) begin
        ovf <= 1'b1;
      end
      // later cell wins a tie
      if (d_out_valid && (state == ST_NEAR || state == ST_NEAR_END) &&
          (!near_have || d_dist <= bestd)) begin
        best      <= d_out_idx;
        bestd     <= d_dist;
        near_have <= 1'b1;
      end
    end
  end

  assign result.valid    = res_valid;
  assign result.found    = res_found;
  assign result.cell_x   = res_x;
  assign result.cell_z   = res_z;
  assign result.overflow = res_ovf;

  gofs_ram #(.WIDTH(ROW_W), .DEPTH(NCELLS)) u_cell_mem (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .re    (cm_re),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

  gofs_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_visit_mem (
    .clk   (clk),
    .we    (vm_we),
    .waddr (vm_waddr),
    .wdata (vm_wdata),
    .re    (vm_re),
    .raddr (vm_raddr),
    .rdata (vm_rdata)
  );

  gofs_ram #(.WIDTH(CELL_W), .DEPTH(QUEUE_DEPTH)) u_queue_mem (
    .clk   (clk),
    .we    (qm_we),
    .waddr (qm_waddr),
    .wdata (qm_wdata),
    .re    (qm_re),
    .raddr (qm_raddr),
    .rdata (qm_rdata)
  );

  gofs_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_q),
    .in_valid  (d_in_valid),
    .in_idx    (d_in_idx),
    .qx        (d_qx),
    .qy        (d_qy),
    .qz        (d_qz),
    .out_valid (d_out_valid),
    .out_idx   (d_out_idx),
    .sq_dist   (d_dist)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEQ || state == ST_NB) |-> cnt <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("search queue count past depth");

  a_mark_write_window: assert property (@(posedge clk) disable iff (rst)
    mk_valid |-> (state == ST_MARK || state == ST_MARK_END))
    else $error("mark write outside mark sweep");

  a_nb_not_self: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NB_CHK) |-> (nb_q != cur))
    else $error("flood probed its own cell");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NB_DIST && !d_out_valid) |=> (state == ST_NB_DIST))
    else $error("distance wait left early");

endmodule

// ===== tb/sv/grid_occupancy_free_cell_search_tb.sv =====
module grid_occupancy_free_cell_search_tb import gofs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 50_000_000;

  typedef struct {
    action_t            act;
    logic [7:0]         id;
    logic signed [15:0] px, py, pz;
    logic [14:0]        hw, hd;
    logic signed [15:0] ox, oy, oz;
    logic               diag;
  } cmd_t;

  typedef struct packed {
    logic       found;
    logic [4:0] cx;
    logic [4:0] cz;
    logic       ovf;
  } grid_res_t;

  logic clk;
  logic rst;

  gofs_cfg_if  cfg ();
  gofs_item_if item ();
  gofs_res_if  result ();

  grid_occupancy_free_cell_search dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg.sink),
    .item   (item.sink),
    .result (result.source)
  );

  // shadow of the grid and its registers
  longint     c_ox = 0, c_oy = 0, c_oz = 0, c_s = 16, c_g = 512, c_n = 32;
  logic [2:0] occ_count [NCELLS] = '{default: '0};
  logic [7:0] occ_ids [NCELLS][ACTOR_SLOTS];
  bit         seen_map [NCELLS];
  int         flood_fifo [NCELLS];

  cmd_t      pending_cmds[$];
  grid_res_t expected_results[$];
  cmd_t      cur_cmd;
  int        fails = 0;
  longint    cycles = 0;
  int        acc_by_action [4] = '{default: 0};
  int        n_found = 0, n_ovf = 0, n_results = 0;
  int        gap_left = 0, burst_left = 1;
  int        long_hold_req = 0, long_hold_seen = 0, hold_left = 0, mode_left = 0, rx_mode = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void add_cmd(cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic int side_n();
    if (c_n == 0) return 1;
    if (c_n > MAX_SIDE) return MAX_SIDE;
    return int'(c_n);
  endfunction

  function automatic longint cen2x(int cx);
    return 2 * c_ox - c_g + c_s + 2 * c_s * cx;
  endfunction

  function automatic longint cen2z(int cz);
    return 2 * c_s * cz - 2 * c_oz - c_g + c_s;
  endfunction

  function automatic longint dist_sq(int idx, longint qx, longint qy, longint qz);
    longint dx, dy, dz;
    dx = cen2x(idx % MAX_SIDE) - 2 * qx;
    dy = 2 * c_oy - 2 * qy;
    dz = cen2z(idx / MAX_SIDE) - 2 * qz;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic bit free_for(int idx, logic [7:0] owner);
    if (occ_count[idx] > 1) return 0;
    if (occ_count[idx] == 1 && occ_ids[idx][0] != owner) return 0;
    return 1;
  endfunction

  function automatic bit holds_id(int idx, logic [7:0] who);
    int m;
    m = occ_count[idx] < ACTOR_SLOTS ? occ_count[idx] : ACTOR_SLOTS;
    for (int k = 0; k < m; k++) if (occ_ids[idx][k] == who) return 1;
    return 0;
  endfunction

  function automatic logic mark_box(cmd_t c);
    longint l, r, d, t, x, z;
    int idx, n;
    logic ovf;
    n = side_n();
    ovf = 0;
    l = 2 * longint'(c.px) - 2 * longint'(c.hw);
    r = 2 * longint'(c.px) + 2 * longint'(c.hw);
    d = 2 * longint'(c.pz) - 2 * longint'(c.hd);
    t = 2 * longint'(c.pz) + 2 * longint'(c.hd);
    for (int cz = 0; cz < n; cz++) begin
      for (int cx = 0; cx < n; cx++) begin
        x = cen2x(cx);
        z = cen2z(cz);
        idx = cz * MAX_SIDE + cx;
        if ((l > x - c_s ? l : x - c_s) > (r < x + c_s ? r : x + c_s)) continue;
        if ((d > z - c_s ? d : z - c_s) > (t < z + c_s ? t : z + c_s)) continue;
        if (occ_count[idx] < ACTOR_SLOTS && occ_count[idx] < COUNT_MAX)
          occ_ids[idx][occ_count[idx]] = c.id;
        else
          ovf = 1;
        if (occ_count[idx] < COUNT_MAX) occ_count[idx] = occ_count[idx] + 3'd1;
      end
    end
    return ovf;
  endfunction

  function automatic int nearest_idx(longint qx, longint qy, longint qz);
    int best, n, idx;
    longint bd, dd;
    n = side_n();
    best = 0;
    bd = 0;
    for (int cz = 0; cz < n; cz++) begin
      for (int cx = 0; cx < n; cx++) begin
        idx = cz * MAX_SIDE + cx;
        dd = dist_sq(idx, qx, qy, qz);
        // later cell wins a tie
        if ((cz == 0 && cx == 0) || dd <= bd) begin
          best = idx;
          bd = dd;
        end
      end
    end
    return best;
  endfunction

  // returns -1 when no free cell is reached
  function automatic int flood_free(int start, cmd_t c);
    int head, qn, cur, nx, nz, nb, best, n;
    bit have;
    logic [7:0] blocker;
    n = side_n();
    if (free_for(start, c.id)) return start;
    blocker = occ_ids[start][0];
    foreach (seen_map[i]) seen_map[i] = 0;
    flood_fifo[0] = start;
    head = 0;
    qn = 1;
    seen_map[start] = 1;
    have = 0;
    best = 0;
    while (qn > 0) begin
      cur = flood_fifo[head];
      head = (head + 1) % NCELLS;
      qn--;
      for (int dx = -1; dx <= 1; dx++) begin
        for (int dz = -1; dz <= 1; dz++) begin
          if (dx == 0 && dz == 0) continue;
          if (!c.diag && dx != 0 && dz != 0) continue;
          nx = cur % MAX_SIDE + dx;
          nz = cur / MAX_SIDE + dz;
          if (nx < 0 || nz < 0 || nx >= n || nz >= n) continue;
          nb = nz * MAX_SIDE + nx;
          if (free_for(nb, c.id) && (!have || dist_sq(nb, c.ox, c.oy, c.oz) <
                                      dist_sq(best, c.ox, c.oy, c.oz))) begin
            best = nb;
            have = 1;
            continue;
          end
          if (!seen_map[nb] && holds_id(nb, blocker) && qn < NCELLS) begin
            flood_fifo[(head + qn) % NCELLS] = nb;
            qn++;
            seen_map[nb] = 1;
          end
        end
      end
    end
    return have ? best : -1;
  endfunction

  function automatic grid_res_t predict_grid(cmd_t c);
    grid_res_t r;
    int idx;
    r = '0;
    case (c.act)
      ACT_MARK: begin
        r.ovf = mark_box(c);
      end
      ACT_CLEAR: begin
        foreach (occ_count[i]) occ_count[i] = '0;
      end
      ACT_NEAREST: begin
        idx = nearest_idx(c.px, c.py, c.pz);
        r.found = 1;
        r.cx = idx[4:0];
        r.cz = idx[9:5];
      end
      default: begin
        idx = flood_free(nearest_idx(c.px, c.py, c.pz), c);
        if (idx >= 0) begin
          r.found = 1;
          r.cx = idx[4:0];
          r.cz = idx[9:5];
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] aim_x();
    return clamp16((cen2x($urandom_range(0, side_n() - 1)) +
                    longint'($urandom_range(0, 2 * c_s)) - c_s) / 2);
  endfunction

  function automatic logic signed [15:0] aim_z();
    return clamp16((cen2z($urandom_range(0, side_n() - 1)) +
                    longint'($urandom_range(0, 2 * c_s)) - c_s) / 2);
  endfunction

  function automatic cmd_t mk(action_t a, logic [7:0] id, longint px, longint py, longint pz,
                              longint hw, longint hd, longint ox, longint oy, longint oz,
                              logic diag);
    cmd_t c;
    c.act = a;
    c.id = id;
    c.px = clamp16(px);
    c.py = clamp16(py);
    c.pz = clamp16(pz);
    c.hw = hw[14:0];
    c.hd = hd[14:0];
    c.ox = clamp16(ox);
    c.oy = clamp16(oy);
    c.oz = clamp16(oz);
    c.diag = diag;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int sel;
    longint span;
    c.id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(10 + $urandom_range(0, 3));
    c.px = 16'($urandom);
    c.py = 16'($urandom);
    c.pz = 16'($urandom);
    c.hw = 15'($urandom);
    c.hd = 15'($urandom);
    c.ox = 16'($urandom);
    c.oy = 16'($urandom);
    c.oz = 16'($urandom);
    c.diag = 1'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 5) c.act = ACT_CLEAR;
    else if (sel < 45) c.act = ACT_MARK;
    else if (sel < 60) c.act = ACT_NEAREST;
    else c.act = ACT_FIND_FREE;
    // mostly aim at the grid so marks build blocked regions for the flood
    if ($urandom_range(0, 9) != 0) begin
      span = c_s > 16383 ? 32767 : 2 * c_s;
      c.px = aim_x();
      c.pz = aim_z();
      c.py = clamp16(c_oy + $urandom_range(0, 20) - 10);
      c.hw = 15'($urandom_range(0, span + 3));
      c.hd = 15'($urandom_range(0, span + 3));
      c.ox = aim_x();
      c.oy = clamp16(c_oy + $urandom_range(0, 20) - 10);
      c.oz = aim_z();
    end
    return c;
  endfunction

  task automatic write_reg(reg_idx_t r, logic [15:0] v);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= r;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (r)
      REG_ORIGIN_X:  c_ox = longint'($signed(v));
      REG_ORIGIN_Y:  c_oy = longint'($signed(v));
      REG_ORIGIN_Z:  c_oz = longint'($signed(v));
      REG_CELL_SIZE: c_s  = longint'(v[14:0]);
      REG_GRID_SIDE: c_g  = longint'(v[14:0]);
      default:       c_n  = longint'(v[5:0]);
    endcase
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || item.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // sender: bursts of random length, random gaps, hold while stalled
  always @(posedge clk) begin
    logic nv;
    grid_res_t pr;
    nv = 1'b0;
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        pr = predict_grid(cur_cmd);
        expected_results = {expected_results, pr};
        acc_by_action[cur_cmd.act]++;
      end
      if (item.valid && !item.ready) begin
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() != 0) begin
        cur_cmd = pending_cmds.pop_front();
        nv = 1'b1;
        item.action     <= cur_cmd.act;
        item.actor_id   <= cur_cmd.id;
        item.point_x    <= cur_cmd.px;
        item.point_y    <= cur_cmd.py;
        item.point_z    <= cur_cmd.pz;
        item.half_width <= cur_cmd.hw;
        item.half_depth <= cur_cmd.hd;
        item.owner_x    <= cur_cmd.ox;
        item.owner_y    <= cur_cmd.oy;
        item.owner_z    <= cur_cmd.oz;
        item.diagonal   <= cur_cmd.diag;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1500)
                                                 : $urandom_range(0, 4);
        end
      end
      item.valid <= nv;
    end
  end

  // receiver: changing stall patterns, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (long_hold_req != long_hold_seen) begin
        long_hold_seen = long_hold_req;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(50, 3000);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0:       result.ready <= 1'b1;
          1:       result.ready <= 1'($urandom_range(0, 1));
          default: result.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // compare each transfer with the oldest prediction
  always @(posedge clk) begin
    grid_res_t e;
    if (!rst && result.valid && result.ready) begin
      n_results++;
      if (result.found) n_found++;
      if (result.overflow) n_ovf++;
      if (expected_results.size() == 0) begin
        fails++;
        $display("%0t: unexpected result found=%0b cell_x=%0d cell_z=%0d overflow=%0b",
                 $time, result.found, result.cell_x, result.cell_z, result.overflow);
      end else begin
        e = expected_results.pop_front();
        if (result.found !== e.found) begin
          fails++;
          $display("%0t: found expected %0b actual %0b", $time, e.found, result.found);
        end
        if (result.cell_x !== e.cx) begin
          fails++;
          $display("%0t: cell_x expected %0d actual %0d", $time, e.cx, result.cell_x);
        end
        if (result.cell_z !== e.cz) begin
          fails++;
          $display("%0t: cell_z expected %0d actual %0d", $time, e.cz, result.cell_z);
        end
        if (result.overflow !== e.ovf) begin
          fails++;
          $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, result.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int ph_ox [6] = '{-32768, 32767, 100, -1000, 0, 37};
    int ph_oy [6] = '{32767, -32768, -50, 0, 16, 5};
    int ph_oz [6] = '{-32768, 32767, 200, 500, 0, -90};
    int ph_s [6]  = '{1, 32767, 40, 0, 24, 12};
    int ph_g [6]  = '{1, 32767, 300, 64, 400, 200};
    int ph_n [6]  = '{1, 8, 0, 4, 63, 16};
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset geometry: column/row k centered at -248 + 16k
    add_cmd(mk(ACT_NEAREST, 0, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(ACT_NEAREST, 255, 32767, 32767, 32767, 0, 0, 0, 0, 0, 1));
    add_cmd(mk(ACT_FIND_FREE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(ACT_MARK, 5, -88, 0, -88, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(ACT_MARK, 5, -88, 0, -88, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(ACT_FIND_FREE, 5, -88, 0, -88, 0, 0, -60, 0, -120, 0));
    add_cmd(mk(ACT_FIND_FREE, 5, -88, 0, -88, 0, 0, -60, 0, -120, 1));
    add_cmd(mk(ACT_MARK, 0, -72, 0, -88, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(ACT_FIND_FREE, 0, -72, 0, -88, 0, 0, 0, 0, 0, 0));
    add_cmd(mk(ACT_MARK, 9, -88, 0, -56, 8, 24, 0, 0, 0, 0));
    add_cmd(mk(ACT_FIND_FREE, 1, -88, 0, -40, 0, 0, -88, 0, 200, 1));
    for (int k = 0; k < 7; k++)
      add_cmd(mk(ACT_MARK, 255, 0, 0, 0, 32767, 32767, 0, 0, 0, 0));
    add_cmd(mk(ACT_FIND_FREE, 255, 40, 0, 40, 0, 0, 0, 0, 0, 1));
    add_cmd(mk(ACT_CLEAR, 255, -1, -1, -1, 32767, 32767, -1, -1, -1, 1));
    add_cmd(mk(ACT_MARK, 3, -32768, 0, 32767, 32767, 0, 0, 0, 0, 0));
    add_cmd(mk(ACT_FIND_FREE, 4, -32768, 0, 32767, 0, 0, 32767, -32768, -32768, 0));
    add_cmd(mk(ACT_NEAREST, 0, 0, -32768, 0, 0, 0, 0, 0, 0, 0));
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_ORIGIN_X, 16'(ph_ox[p]));
      write_reg(REG_ORIGIN_Y, 16'(ph_oy[p]));
      write_reg(REG_ORIGIN_Z, 16'(ph_oz[p]));
      write_reg(REG_CELL_SIZE, 16'(ph_s[p]));
      write_reg(REG_GRID_SIDE, 16'(ph_g[p]));
      write_reg(REG_CELLS_PER_SIDE, 16'(ph_n[p]));
      for (int k = 0; k < 45; k++) add_cmd(rand_cmd());
      // let results back up until the input stalls
      if (p == 2) long_hold_req++;
      drain();
    end

    $display("covered %0d marks, %0d clears, %0d nearest, %0d find-free over 7 geometries",
             acc_by_action[ACT_MARK], acc_by_action[ACT_CLEAR],
             acc_by_action[ACT_NEAREST], acc_by_action[ACT_FIND_FREE]);
    $display("%0d results checked, %0d with a cell, %0d with overflow",
             n_results, n_found, n_ovf);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
